FILE: src/gic_pkg.sv
// gic_pkg: shared types and constants for the gamepad input conditioner.
// Used by gic_front, gic_queue, gic_back and the top level. No dependencies.
package gic_pkg;

   localparam int NUM_PADS = 4;

   localparam int PAD_W    = 2;
   localparam int BTN_W    = 16;
   localparam int AXIS_W   = 8;
   localparam int LIMIT_W  = 7;
   localparam int STATUS_W = 8;
   localparam int TIMER_W  = 8;

   // Register indexes on the csr port
   localparam logic CSR_STICK_X_LIMIT = 1'b0;
   localparam logic CSR_STICK_Y_LIMIT = 1'b1;

   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 7'd70;
   localparam logic [STATUS_W-1:0] NO_RESPONSE  = 8'd8;
   localparam logic [TIMER_W-1:0]  REPEAT_FIRST = 8'h1E;
   localparam logic [TIMER_W-1:0]  REPEAT_NEXT  = 8'h0A;
   localparam logic signed [AXIS_W-1:0] DEAD_HI = 8'sd9;
   localparam logic signed [AXIS_W-1:0] DEAD_LO = -8'sd9;

   // Item after the front end: sticks conditioned, status reduced.
   typedef struct packed {
      logic [PAD_W-1:0]         pad;
      logic                     connected;
      logic [BTN_W-1:0]         buttons;
      logic signed [AXIS_W-1:0] stick_x;
      logic signed [AXIS_W-1:0] stick_y;
   } front_item_type;

   typedef struct packed {
      logic [PAD_W-1:0]         pad;
      logic                     connected;
      logic [BTN_W-1:0]         held;
      logic [BTN_W-1:0]         pressed;
      logic [BTN_W-1:0]         repeats;
      logic signed [AXIS_W-1:0] stick_x;
      logic signed [AXIS_W-1:0] stick_y;
   } rsp_item_type;

   // Handshake status of a queue as seen by its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Dead zone of -9..9, then clamp to +/- limit.
   function automatic logic signed [AXIS_W-1:0] condition_axis(
      input logic signed [AXIS_W-1:0] raw,
      input logic [LIMIT_W-1:0]       limit
   );
      logic signed [AXIS_W:0] v;
      logic signed [AXIS_W:0] pos;
      logic signed [AXIS_W:0] neg;
      logic signed [AXIS_W:0] r;
      v   = {raw[AXIS_W-1], raw};
      pos = {2'b00, limit};
      neg = -pos;
      if (raw >= DEAD_LO && raw <= DEAD_HI) begin
         r = '0;
      end else if (v > pos) begin
         r = pos;
      end else if (v < neg) begin
         r = neg;
      end else begin
         r = v;
      end
      return r[AXIS_W-1:0];
   endfunction

endpackage

FILE: src/gic_front.sv
// gic_front: input side. Holds the stick limit registers, conditions the
// sticks and status of each accepted sample. Depends on gic_pkg.
module gic_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [gic_pkg::LIMIT_W-1:0]         csr_wdata,
   input  logic                                req_push,
   input  logic [gic_pkg::PAD_W-1:0]           req_pad_index,
   input  logic [gic_pkg::BTN_W-1:0]           req_button_word,
   input  logic signed [gic_pkg::AXIS_W-1:0]   req_raw_stick_x,
   input  logic signed [gic_pkg::AXIS_W-1:0]   req_raw_stick_y,
   input  logic [gic_pkg::STATUS_W-1:0]        req_status_byte,
   input  gic_pkg::queue_status_type           q_status,
   output logic                                q_push,
   output gic_pkg::front_item_type             q_item
);

   logic [gic_pkg::LIMIT_W-1:0] x_limit_ff, x_limit_in;
   logic [gic_pkg::LIMIT_W-1:0] y_limit_ff, y_limit_in;

   always_comb begin
      x_limit_in = x_limit_ff;
      y_limit_in = y_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            gic_pkg::CSR_STICK_X_LIMIT: x_limit_in = csr_wdata;
            gic_pkg::CSR_STICK_Y_LIMIT: y_limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= gic_pkg::LIMIT_RESET;
         y_limit_ff <= gic_pkg::LIMIT_RESET;
      end else begin
         x_limit_ff <= x_limit_in;
         y_limit_ff <= y_limit_in;
      end
   end

   assign q_push = req_push & ~q_status.full;

   always_comb begin
      q_item.pad       = req_pad_index;
      q_item.connected = (req_status_byte != gic_pkg::NO_RESPONSE);
      q_item.buttons   = req_button_word;
      q_item.stick_x   = gic_pkg::condition_axis(req_raw_stick_x, x_limit_ff);
      q_item.stick_y   = gic_pkg::condition_axis(req_raw_stick_y, y_limit_ff);
   end

endmodule

FILE: src/gic_queue.sv
// gic_queue: two-entry queue between front and back ends.
// Depends on gic_pkg for the item type.
module gic_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  gic_pkg::front_item_type  push_item,
   input  logic                     pop,
   output gic_pkg::front_item_type  head_item,
   output gic_pkg::queue_status_type status
);

   gic_pkg::front_item_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = mem_ff[rd_ptr_ff];
   assign status.full  = (cnt_ff == 2'd2);
   assign status.empty = (cnt_ff == 2'd0);

endmodule

FILE: src/gic_back.sv
// gic_back: back end. Per-pad button history and repeat timers, result
// computation and a two-entry result buffer. Depends on gic_pkg.
module gic_back (
   input  logic                      clock,
   input  logic                      reset,
   input  gic_pkg::front_item_type   q_head,
   input  gic_pkg::queue_status_type q_status,
   output logic                      q_pop,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output gic_pkg::rsp_item_type     rsp_item
);

   logic [gic_pkg::BTN_W-1:0]   last_ff  [gic_pkg::NUM_PADS];
   logic [gic_pkg::TIMER_W-1:0] timer_ff [gic_pkg::NUM_PADS];

   gic_pkg::rsp_item_type out_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   logic                        pad_ok;
   logic [gic_pkg::BTN_W-1:0]   prev;
   logic                        changed;
   logic [gic_pkg::TIMER_W-1:0] dec;
   logic [gic_pkg::TIMER_W-1:0] timer_next;
   logic                        out_pop;
   gic_pkg::rsp_item_type       res;

   assign out_pop = rsp_pop & ~rsp_empty;
   assign q_pop   = ~q_status.empty & (cnt_ff != 2'd2);

   always_comb begin
      pad_ok  = (int'(q_head.pad) < gic_pkg::NUM_PADS);
      prev    = last_ff[q_head.pad];
      changed = (prev != q_head.buttons);
      dec     = timer_ff[q_head.pad] - 8'd1;

      res.pad       = q_head.pad;
      res.connected = q_head.connected;
      res.held      = q_head.buttons;
      res.stick_x   = q_head.stick_x;
      res.stick_y   = q_head.stick_y;
      res.pressed   = '0;
      res.repeats   = '0;
      timer_next    = dec;
      if (pad_ok) begin
         res.pressed = q_head.buttons & (q_head.buttons ^ prev);
         if (changed) begin
            res.repeats = res.pressed;
            timer_next  = gic_pkg::REPEAT_FIRST;
         end else if (dec == '0) begin
            res.repeats = q_head.buttons;
            timer_next  = gic_pkg::REPEAT_NEXT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gic_pkg::NUM_PADS; i++) begin
            last_ff[i]  <= '0;
            timer_ff[i] <= '0;
         end
      end else if (q_pop && pad_ok) begin
         last_ff[q_head.pad]  <= q_head.buttons;
         timer_ff[q_head.pad] <= timer_next;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ q_pop;
      rd_ptr_in = rd_ptr_ff ^ out_pop;
      cnt_in    = cnt_ff + {1'b0, q_pop} - {1'b0, out_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_ff[wr_ptr_ff] <= res;
      end
   end

   assign rsp_item  = out_ff[rd_ptr_ff];
   assign rsp_empty = (cnt_ff == 2'd0);

`ifndef SYNTH
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result buffer count out of range");

   a_pressed_subset: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (res.pressed & ~res.held) == '0)
      else $error("pressed bit set for a button not held");

   a_repeat_hold: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !changed && res.repeats != '0) |-> res.repeats == res.held)
      else $error("repeat strobe without change differs from held set");

   a_history: assert property (@(posedge clock) disable iff (reset)
      (q_pop && pad_ok) |=> last_ff[$past(q_head.pad)] == $past(q_head.buttons))
      else $error("button history not updated");
`endif

endmodule

FILE: src/gamepad_input_conditioner_unit.sv
// gamepad_input_conditioner_unit: top level of the gamepad input conditioner.
// Depends on gic_pkg, gic_front, gic_queue and gic_back.
//
//  channel | ports                      | beat accepted when
//  --------+----------------------------+---------------------------
//  req     | req_push / req_full        | req_push && !req_full
//  rsp     | rsp_empty / rsp_pop        | rsp_pop && !rsp_empty
//  csr     | csr_we, csr_index, wdata   | csr_we
//
// One beat per cycle sustained in both directions while neither side
// stalls. An accepted sample waits in the front queue, is popped into the
// registered result buffer when it has room and leaves with rsp_pop high.
// The per-pad history read-modify-write in the back end is done at the pop,
// so consecutive beats on the same pad chain without a bubble. Each side
// has a two-entry queue, so a stalled rsp pop backs up into req_full only
// after both fill. Reset is synchronous and clears limits to 70, all pad
// history and timers, and both queues.
module gamepad_input_conditioner_unit (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [gic_pkg::LIMIT_W-1:0]         csr_wdata,
   // sample input
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [gic_pkg::PAD_W-1:0]           req_pad_index,
   input  logic [gic_pkg::BTN_W-1:0]           req_button_word,
   input  logic signed [gic_pkg::AXIS_W-1:0]   req_raw_stick_x,
   input  logic signed [gic_pkg::AXIS_W-1:0]   req_raw_stick_y,
   input  logic [gic_pkg::STATUS_W-1:0]        req_status_byte,
   // results
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [gic_pkg::PAD_W-1:0]           rsp_out_pad,
   output logic                                rsp_connected,
   output logic [gic_pkg::BTN_W-1:0]           rsp_held_buttons,
   output logic [gic_pkg::BTN_W-1:0]           rsp_pressed_buttons,
   output logic [gic_pkg::BTN_W-1:0]           rsp_repeat_buttons,
   output logic signed [gic_pkg::AXIS_W-1:0]   rsp_stick_x,
   output logic signed [gic_pkg::AXIS_W-1:0]   rsp_stick_y
);

   gic_pkg::front_item_type   push_item;
   gic_pkg::front_item_type   head_item;
   gic_pkg::queue_status_type q_status;
   gic_pkg::rsp_item_type     rsp_item;
   logic                      q_push;
   logic                      q_pop;

   // Front end: limit registers and stick / status conditioning.
   gic_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_push        (req_push),
      .req_pad_index   (req_pad_index),
      .req_button_word (req_button_word),
      .req_raw_stick_x (req_raw_stick_x),
      .req_raw_stick_y (req_raw_stick_y),
      .req_status_byte (req_status_byte),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_item          (push_item)
   );

   // Decoupling queue: lets either side stall without stopping the other.
   gic_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   // Back end: per-pad edge detect, auto-repeat timers, result buffer.
   gic_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (head_item),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item)
   );

   assign req_full            = q_status.full;
   assign rsp_out_pad         = rsp_item.pad;
   assign rsp_connected       = rsp_item.connected;
   assign rsp_held_buttons    = rsp_item.held;
   assign rsp_pressed_buttons = rsp_item.pressed;
   assign rsp_repeat_buttons  = rsp_item.repeats;
   assign rsp_stick_x         = rsp_item.stick_x;
   assign rsp_stick_y         = rsp_item.stick_y;

endmodule

FILE: tb/sv/gamepad_input_conditioner_unit_tb.sv
// Testbench for gamepad_input_conditioner_unit: directed and random controller samples,
// with per-pad button history, repeat timers and stick shaping predicted in a scoreboard.
// Depends on gic_pkg and the gamepad_input_conditioner_unit RTL.
`timescale 1ns / 1ps

class pad_scoreboard;
   logic [gic_pkg::BTN_W-1:0]   last_btn [gic_pkg::NUM_PADS];
   logic [gic_pkg::TIMER_W-1:0] rpt_timer [gic_pkg::NUM_PADS];
   logic [gic_pkg::LIMIT_W-1:0] x_lim;
   logic [gic_pkg::LIMIT_W-1:0] y_lim;
   gic_pkg::rsp_item_type       expected_q [$];
   int                          fails;

   function new();
      for (int i = 0; i < gic_pkg::NUM_PADS; i++) begin
         last_btn[i]  = '0;
         rpt_timer[i] = '0;
      end
      x_lim = gic_pkg::LIMIT_RESET;
      y_lim = gic_pkg::LIMIT_RESET;
      fails = 0;
   endfunction

   function void set_limits(logic [gic_pkg::LIMIT_W-1:0] x, logic [gic_pkg::LIMIT_W-1:0] y);
      x_lim = x;
      y_lim = y;
   endfunction

   // Dead zone, then clamp to +/- limit.
   function logic [gic_pkg::AXIS_W-1:0] shape_axis(logic signed [gic_pkg::AXIS_W-1:0] raw,
                                                   logic [gic_pkg::LIMIT_W-1:0] limit);
      int v;
      int lim;
      int r;
      v   = raw;
      lim = limit;
      if (v >= gic_pkg::DEAD_LO && v <= gic_pkg::DEAD_HI) r = 0;
      else if (v > lim) r = lim;
      else if (v < -lim) r = -lim;
      else r = v;
      return r[gic_pkg::AXIS_W-1:0];
   endfunction

   // Called for every accepted sample beat; advances the pad history.
   function void note_sample(logic [gic_pkg::PAD_W-1:0] pad, logic [gic_pkg::BTN_W-1:0] word,
                             logic signed [gic_pkg::AXIS_W-1:0] sx,
                             logic signed [gic_pkg::AXIS_W-1:0] sy,
                             logic [gic_pkg::STATUS_W-1:0] status);
      gic_pkg::rsp_item_type     e;
      logic [gic_pkg::BTN_W-1:0] prev;
      e.pad       = pad;
      e.connected = (status != gic_pkg::NO_RESPONSE);
      e.held      = word;
      e.pressed   = '0;
      e.repeats   = '0;
      if (int'(pad) < gic_pkg::NUM_PADS) begin
         prev      = last_btn[pad];
         e.pressed = word & (word ^ prev);
         if (prev != word) begin
            e.repeats      = e.pressed;
            rpt_timer[pad] = gic_pkg::REPEAT_FIRST;
         end else begin
            rpt_timer[pad] = rpt_timer[pad] - 8'd1;
            if (rpt_timer[pad] == '0) begin
               e.repeats      = word;
               rpt_timer[pad] = gic_pkg::REPEAT_NEXT;
            end
         end
         last_btn[pad] = word;
      end
      e.stick_x = shape_axis(sx, x_lim);
      e.stick_y = shape_axis(sy, y_lim);
      expected_q.push_back(e);
   endfunction

   function void cmp(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
         fails++;
      end
   endfunction

   // Called for every accepted result beat.
   function void check_result(gic_pkg::rsp_item_type got);
      gic_pkg::rsp_item_type e;
      if (expected_q.size() == 0) begin
         $error("result beat with nothing expected: pad %0d held %0h", got.pad, got.held);
         fails++;
         return;
      end
      e = expected_q.pop_front();
      cmp("out_pad", 16'(e.pad), 16'(got.pad));
      cmp("connected", 16'(e.connected), 16'(got.connected));
      cmp("held_buttons", e.held, got.held);
      cmp("pressed_buttons", e.pressed, got.pressed);
      cmp("repeat_buttons", e.repeats, got.repeats);
      cmp("stick_x", 16'(e.stick_x), 16'(got.stick_x));
      cmp("stick_y", 16'(e.stick_y), 16'(got.stick_y));
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module gamepad_input_conditioner_unit_tb;

   // One controller sample as driven on the req channel.
   typedef struct packed {
      logic [gic_pkg::PAD_W-1:0]         pad;
      logic [gic_pkg::BTN_W-1:0]         word;
      logic signed [gic_pkg::AXIS_W-1:0] sx;
      logic signed [gic_pkg::AXIS_W-1:0] sy;
      logic [gic_pkg::STATUS_W-1:0]      status;
   } pad_sample_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              csr_we;
   logic                              csr_index;
   logic [gic_pkg::LIMIT_W-1:0]       csr_wdata;
   logic                              req_push;
   logic                              req_full;
   logic [gic_pkg::PAD_W-1:0]         req_pad_index;
   logic [gic_pkg::BTN_W-1:0]         req_button_word;
   logic signed [gic_pkg::AXIS_W-1:0] req_raw_stick_x;
   logic signed [gic_pkg::AXIS_W-1:0] req_raw_stick_y;
   logic [gic_pkg::STATUS_W-1:0]      req_status_byte;
   logic                              rsp_empty;
   logic                              rsp_pop;
   logic [gic_pkg::PAD_W-1:0]         rsp_out_pad;
   logic                              rsp_connected;
   logic [gic_pkg::BTN_W-1:0]         rsp_held_buttons;
   logic [gic_pkg::BTN_W-1:0]         rsp_pressed_buttons;
   logic [gic_pkg::BTN_W-1:0]         rsp_repeat_buttons;
   logic signed [gic_pkg::AXIS_W-1:0] rsp_stick_x;
   logic signed [gic_pkg::AXIS_W-1:0] rsp_stick_y;

   pad_scoreboard                sb = new();
   gic_pkg::rsp_item_type        got_beat;
   bit                           quiet_tail = 1'b0;   // no idling on either side when set
   logic [gic_pkg::BTN_W-1:0]    sent_word [gic_pkg::NUM_PADS]; // last word driven per pad
   logic [gic_pkg::LIMIT_W-1:0]  cur_x_lim;
   logic [gic_pkg::LIMIT_W-1:0]  cur_y_lim;

   gamepad_input_conditioner_unit dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_pad_index       (req_pad_index),
      .req_button_word     (req_button_word),
      .req_raw_stick_x     (req_raw_stick_x),
      .req_raw_stick_y     (req_raw_stick_y),
      .req_status_byte     (req_status_byte),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_out_pad         (rsp_out_pad),
      .rsp_connected       (rsp_connected),
      .rsp_held_buttons    (rsp_held_buttons),
      .rsp_pressed_buttons (rsp_pressed_buttons),
      .rsp_repeat_buttons  (rsp_repeat_buttons),
      .rsp_stick_x         (rsp_stick_x),
      .rsp_stick_y         (rsp_stick_y)
   );

   always #2 clock = ~clock;

   // Monitor: inputs are driven by NBA at the edge, so here we see the
   // values that held just before the edge on both channels.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            sb.note_sample(req_pad_index, req_button_word, req_raw_stick_x,
                           req_raw_stick_y, req_status_byte);
         end
         if (rsp_pop && !rsp_empty) begin
            got_beat.pad       = rsp_out_pad;
            got_beat.connected = rsp_connected;
            got_beat.held      = rsp_held_buttons;
            got_beat.pressed   = rsp_pressed_buttons;
            got_beat.repeats   = rsp_repeat_buttons;
            got_beat.stick_x   = rsp_stick_x;
            got_beat.stick_y   = rsp_stick_y;
            sb.check_result(got_beat);
         end
      end
   end

   function automatic pad_sample_type mk(int pad, int word, int sx, int sy, int status);
      pad_sample_type s;
      s.pad    = pad[gic_pkg::PAD_W-1:0];
      s.word   = word[gic_pkg::BTN_W-1:0];
      s.sx     = sx[gic_pkg::AXIS_W-1:0];
      s.sy     = sy[gic_pkg::AXIS_W-1:0];
      s.status = status[gic_pkg::STATUS_W-1:0];
      return s;
   endfunction

   // Stick values biased toward the dead-zone edges and the clamp points.
   function automatic logic [gic_pkg::AXIS_W-1:0] pick_axis(logic [gic_pkg::LIMIT_W-1:0] lim);
      int v;
      int l;
      l = lim;
      case ($urandom_range(0, 11))
         0: v = -128;
         1: v = 127;
         2: v = -10;
         3: v = -9;
         4: v = 9;
         5: v = 10;
         6: v = l;
         7: v = l + 1;
         8: v = -l;
         9: v = -l - 1;
         default: v = $urandom;
      endcase
      return v[gic_pkg::AXIS_W-1:0];
   endfunction

   // Drive one sample beat and return at the edge where it was taken.
   task automatic push_sample(input pad_sample_type s);
      req_push        <= 1'b1;
      req_pad_index   <= s.pad;
      req_button_word <= s.word;
      req_raw_stick_x <= s.sx;
      req_raw_stick_y <= s.sy;
      req_status_byte <= s.status;
      sent_word[s.pad] = s.word;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic req_gap(input int n);
      req_push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Random sender idling, bursty; none in the tail.
   task automatic maybe_gap(input bit gappy);
      if (!quiet_tail && gappy && $urandom_range(0, 2) == 0) req_gap($urandom_range(1, 6));
   endtask

   // Stop sending and wait until every result beat has been checked.
   // It first waits on the clock so the monitor has logged the last accepted beat.
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Write both limit registers on back-to-back cycles; block is idle here.
   task automatic set_limits(input logic [gic_pkg::LIMIT_W-1:0] x,
                             input logic [gic_pkg::LIMIT_W-1:0] y);
      csr_we    <= 1'b1;
      csr_index <= gic_pkg::CSR_STICK_X_LIMIT;
      csr_wdata <= x;
      @(posedge clock);
      csr_index <= gic_pkg::CSR_STICK_Y_LIMIT;
      csr_wdata <= y;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_limits(x, y);
      cur_x_lim = x;
      cur_y_lim = y;
   endtask

   // Random traffic: runs of one pad holding a word, so the repeat timer gets
   // to its first and later expiries; sprinkled with samples on other pads.
   task automatic random_traffic(input int n_items);
      int                           sent;
      int                           pad;
      int                           run_len;
      bit                           gappy;
      logic [gic_pkg::BTN_W-1:0]    word;
      logic [gic_pkg::STATUS_W-1:0] st;
      sent = 0;
      while (sent < n_items) begin
         pad   = $urandom_range(0, gic_pkg::NUM_PADS - 1);
         gappy = $urandom_range(0, 1);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: word = sent_word[pad];
            4, 5, 6:    word = 16'($urandom);
            7:          word = sent_word[pad] ^ (16'h1 << $urandom_range(0, gic_pkg::BTN_W - 1));
            8:          word = '0;
            default:    word = '1;
         endcase
         run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(8, 45);
         for (int i = 0; i < run_len && sent < n_items; i++) begin
            st = ($urandom_range(0, 3) == 0) ? gic_pkg::NO_RESPONSE : 8'($urandom);
            if ($urandom_range(0, 15) == 0) begin
               // stray sample on some other pad, random content
               push_sample(mk($urandom_range(0, gic_pkg::NUM_PADS - 1), $urandom,
                              pick_axis(cur_x_lim), pick_axis(cur_y_lim), $urandom));
            end else begin
               push_sample(mk(pad, word, pick_axis(cur_x_lim), pick_axis(cur_y_lim), st));
            end
            sent++;
            maybe_gap(gappy);
         end
      end
   endtask

   // Receiver: pop held high or low in random bursts.
   initial begin
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Main sequence: reset, directed samples, then phases of random traffic
   // each under its own pair of stick limits.
   initial begin
      for (int i = 0; i < gic_pkg::NUM_PADS; i++) sent_word[i] = '0;
      cur_x_lim = gic_pkg::LIMIT_RESET;
      cur_y_lim = gic_pkg::LIMIT_RESET;
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= gic_pkg::CSR_STICK_X_LIMIT;
      csr_wdata       <= '0;
      req_push        <= 1'b0;
      req_pad_index   <= '0;
      req_button_word <= '0;
      req_raw_stick_x <= '0;
      req_raw_stick_y <= '0;
      req_status_byte <= '0;
      rsp_pop         <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset limits of 70. First beat: no change on a fresh pad,
      // so the timer wraps and no strobe; status 8 reads as disconnected.
      push_sample(mk(0, 16'h0000, 0, 0, 8));
      push_sample(mk(0, 16'hFFFF, 127, -128, 8'h00));
      push_sample(mk(0, 16'h0000, -9, 9, 8'hFF));
      push_sample(mk(1, 16'hA5A5, 10, -10, 8'h07));
      push_sample(mk(1, 16'h5A5A, 70, -70, 8'h09));
      push_sample(mk(1, 16'h5A5A, 71, -71, 8'h08));
      req_gap(3);
      push_sample(mk(2, 16'h8001, -8, 8, 8'h80));
      push_sample(mk(2, 16'h8003, 69, -69, 8'h01));
      push_sample(mk(3, 16'h0001, -1, 1, 8'h00));
      push_sample(mk(3, 16'h0000, 11, -11, 8'hF7));
      push_sample(mk(2, 16'h0001, -127, 126, 8'h08));
      push_sample(mk(3, 16'hFFFF, -10, 10, 8'h10));
      random_traffic(150);
      drain();

      // Zero x limit squashes every x value; y limit 127 lets -128 clamp to -127.
      set_limits(7'd0, 7'd127);
      push_sample(mk(0, 16'h1234, -128, -128, 8'h00));
      push_sample(mk(1, 16'h4321, 127, 127, 8'h08));
      push_sample(mk(2, 16'h00FF, 10, -10, 8'h55));
      push_sample(mk(3, 16'hFF00, 9, -9, 8'hAA));
      push_sample(mk(0, 16'h1234, -127, 126, 8'h08));
      random_traffic(150);
      drain();

      set_limits(7'd127, 7'd0);
      random_traffic(150);
      drain();

      set_limits(7'd1, 7'd126);
      random_traffic(150);
      drain();

      set_limits(7'($urandom), 7'($urandom));
      random_traffic(150);
      drain();

      // Tail: back-to-back beats both ways.
      set_limits(7'd127, 7'd127);
      quiet_tail = 1'b1;
      random_traffic(180);
      drain();

      if (sb.fails == 0 && sb.pending() == 0) begin
         $display("gamepad_input_conditioner_unit verification clean");
      end else begin
         $display("gamepad_input_conditioner_unit verification failed");
      end
      $finish;
   end

   // Watchdog: the slowest legal run is far below this.
   initial begin
      #2_000_000;
      $display("gamepad_input_conditioner_unit verification failed");
      $finish;
   end

endmodule
